/* hdl/pwt_pkg.sv */
// Shared types and codes for the protobuf wire tokenizer.
`timescale 1ns / 1ps

package pwt_pkg;

  // One message byte as it arrives on the input channel.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } pwt_in_t;

  // One token as it leaves on the result channel.
  typedef struct packed {
    logic [2:0]  token_kind;
    logic [28:0] field_number;
    logic [2:0]  wire_code;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        message_end;
  } pwt_out_t;

  // Classified byte held in the queue between front and back.
  typedef struct packed {
    logic [7:0] byte_data;
    logic [6:0] group7;   // varint payload bits
    logic       more;     // varint continuation bit
    logic       last;     // end of buffer
  } pwt_class_t;

  // Token kinds.
  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIXED32 = 3'd1;
  localparam logic [2:0] KIND_FIXED64 = 3'd2;
  localparam logic [2:0] KIND_HEADER  = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // Error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_WIRE_TYPE = 2'd2;

  // Wire types.
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Byte counts of fixed fields.
  localparam logic [3:0] FIXED64_BYTES = 4'd8;
  localparam logic [3:0] FIXED32_BYTES = 4'd4;

endpackage

/* hdl/pwt_front.sv */
// Input side: accept bytes, classify them and queue them for the back end.
`timescale 1ns / 1ps

module pwt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pwt_pkg::pwt_in_t   in_data,
  output logic               q_valid,
  output pwt_pkg::pwt_class_t q_head,
  input  logic               q_pop
);
  import pwt_pkg::*;

  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  pwt_class_t          q_mem_r [QDepth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  pwt_class_t          cls;
  logic                push, pop;

  // Split the byte into its varint pieces.
  always_comb begin
    cls.byte_data = in_data.data_byte;
    cls.group7    = in_data.data_byte[6:0];
    cls.more      = in_data.data_byte[7];
    cls.last      = in_data.end_of_buffer;
  end

  assign in_stall = (count_r == CntW'(QDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

/* hdl/pwt_back.sv */
// Token engine: walks tag, varint, fixed, length, payload and drain phases and registers the token.
`timescale 1ns / 1ps

module pwt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pwt_pkg::pwt_class_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output pwt_pkg::pwt_out_t   out_data
);
  import pwt_pkg::*;

  typedef enum logic [5:0] {
    PH_TAG     = 6'b000001,
    PH_VARINT  = 6'b000010,
    PH_FIXED   = 6'b000100,
    PH_LENGTH  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DRAIN   = 6'b100000
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [63:0]  acc_r, acc_nxt;
  logic [6:0]   shift_r, shift_nxt;
  logic [28:0]  fnum_r, fnum_nxt;
  logic [2:0]   wtype_r, wtype_nxt;
  logic [3:0]   fixed_left_r, fixed_left_nxt;
  logic [63:0]  pay_left_r, pay_left_nxt;

  logic         out_valid_r, out_valid_nxt;
  pwt_out_t     out_data_r, out_data_nxt;

  logic [63:0]  acc_var, acc_fix;
  logic [6:0]   shift_var, shift_fix;
  logic [3:0]   fixed_dec;
  logic [63:0]  pay_dec;
  logic         emit;
  pwt_out_t     tok;

  // Take a byte whenever the output slot is free or drains this cycle.
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  // Accumulate; bits past the top are dropped and the shift holds.
  always_comb begin
    acc_var   = acc_r;
    acc_fix   = acc_r;
    shift_var = shift_r;
    shift_fix = shift_r;
    if (!shift_r[6]) begin
      acc_var   = acc_r | (64'(q_head.group7) << shift_r[5:0]);
      acc_fix   = acc_r | (64'(q_head.byte_data) << shift_r[5:0]);
      shift_var = shift_r + 7'd7;
      shift_fix = shift_r + 7'd8;
    end
    fixed_dec = (fixed_left_r != '0) ? fixed_left_r - 4'd1 : fixed_left_r;
    pay_dec   = (pay_left_r != '0) ? pay_left_r - 64'd1 : pay_left_r;
  end

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    shift_nxt      = shift_r;
    fnum_nxt       = fnum_r;
    wtype_nxt      = wtype_r;
    fixed_left_nxt = fixed_left_r;
    pay_left_nxt   = pay_left_r;
    emit           = 1'b0;
    tok            = '0;
    tok.error_code = ERR_NONE;

    case (phase_r)
      PH_TAG: begin
        acc_nxt   = acc_var;
        shift_nxt = shift_var;
        if (!q_head.more) begin
          fnum_nxt  = acc_var[31:3];
          wtype_nxt = acc_var[2:0];
          acc_nxt   = '0;
          shift_nxt = '0;
          case (acc_var[2:0])
            WT_VARINT:  phase_nxt = PH_VARINT;
            WT_FIXED64: begin
              phase_nxt      = PH_FIXED;
              fixed_left_nxt = FIXED64_BYTES;
            end
            WT_FIXED32: begin
              phase_nxt      = PH_FIXED;
              fixed_left_nxt = FIXED32_BYTES;
            end
            WT_LEN:     phase_nxt = PH_LENGTH;
            default: begin
              emit           = 1'b1;
              tok.token_kind = KIND_ERROR;
              tok.error_code = ERR_WIRE_TYPE;
              phase_nxt      = PH_DRAIN;
            end
          endcase
        end
        if (!emit && q_head.last) begin
          emit           = 1'b1;
          tok.token_kind = KIND_ERROR;
          tok.error_code = ERR_TRUNCATED;
        end
      end

      PH_VARINT: begin
        acc_nxt   = acc_var;
        shift_nxt = shift_var;
        if (!q_head.more) begin
          emit            = 1'b1;
          tok.token_kind  = KIND_VARINT;
          tok.field_value = acc_var;
          phase_nxt       = PH_TAG;
        end else if (q_head.last) begin
          emit           = 1'b1;
          tok.token_kind = KIND_ERROR;
          tok.error_code = ERR_TRUNCATED;
        end
      end

      PH_FIXED: begin
        acc_nxt        = acc_fix;
        shift_nxt      = shift_fix;
        fixed_left_nxt = fixed_dec;
        if (fixed_dec == '0) begin
          emit            = 1'b1;
          tok.token_kind  = (wtype_r == WT_FIXED64) ? KIND_FIXED64 : KIND_FIXED32;
          tok.field_value = acc_fix;
          phase_nxt       = PH_TAG;
        end else if (q_head.last) begin
          emit           = 1'b1;
          tok.token_kind = KIND_ERROR;
          tok.error_code = ERR_TRUNCATED;
        end
      end

      PH_LENGTH: begin
        acc_nxt   = acc_var;
        shift_nxt = shift_var;
        if (!q_head.more) begin
          emit = 1'b1;
          if (q_head.last && acc_var != '0) begin
            tok.token_kind = KIND_ERROR;
            tok.error_code = ERR_TRUNCATED;
          end else begin
            tok.token_kind  = KIND_HEADER;
            tok.field_value = acc_var;
            if (acc_var == '0) begin
              phase_nxt = PH_TAG;
            end else begin
              phase_nxt    = PH_PAYLOAD;
              pay_left_nxt = acc_var;
              acc_nxt      = '0;
              shift_nxt    = '0;
            end
          end
        end else if (q_head.last) begin
          emit           = 1'b1;
          tok.token_kind = KIND_ERROR;
          tok.error_code = ERR_TRUNCATED;
        end
      end

      PH_PAYLOAD: begin
        pay_left_nxt = pay_dec;
        emit         = 1'b1;
        if (q_head.last && pay_dec != '0) begin
          tok.token_kind = KIND_ERROR;
          tok.error_code = ERR_TRUNCATED;
        end else begin
          tok.token_kind   = KIND_PAYLOAD;
          tok.field_value  = pay_dec;
          tok.payload_byte = q_head.byte_data;
          if (pay_dec == '0) begin
            phase_nxt = PH_TAG;
          end
        end
      end

      PH_DRAIN: begin
        emit = 1'b0;
      end

      default: begin
        phase_nxt = PH_TAG;
      end
    endcase

    tok.field_number = fnum_nxt;
    tok.wire_code    = wtype_nxt;
    tok.message_end  = q_head.last;

    // Return to the tag phase with clean state after a completed field or the last byte.
    // A tag that is still arriving keeps its partial value.
    if ((phase_nxt == PH_TAG && phase_r != PH_TAG) || q_head.last) begin
      phase_nxt      = PH_TAG;
      acc_nxt        = '0;
      shift_nxt      = '0;
      fnum_nxt       = '0;
      wtype_nxt      = '0;
      fixed_left_nxt = '0;
      pay_left_nxt   = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAG;
      acc_r        <= '0;
      shift_r      <= '0;
      fnum_r       <= '0;
      wtype_r      <= '0;
      fixed_left_r <= '0;
      pay_left_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r      <= phase_nxt;
        acc_r        <= acc_nxt;
        shift_r      <= shift_nxt;
        fnum_r       <= fnum_nxt;
        wtype_r      <= wtype_nxt;
        fixed_left_r <= fixed_left_nxt;
        pay_left_r   <= pay_left_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/protobuf_wire_tokenizer.sv */
// Top level of the protobuf wire tokenizer: front queue plus token engine.
`timescale 1ns / 1ps

// Tokenizes one nesting level of a protobuf message, one byte per transfer. Each tag
// is decoded into field number and wire type; the field then yields one token: a
// varint, a little-endian fixed32/fixed64 value, or a length header followed by one
// payload-byte token per payload byte (feed those into a second instance to parse a
// nested message). A tag alone gives no token. Unknown wire types (3, 4, 6, 7) give an
// error token (code 2) and the rest of the message is dropped silently; a message that
// ends in mid-field gives a truncation error (code 1). State clears after every byte
// flagged end_of_buffer. Throughput is one byte per clock sustained while out_stall is
// low: the front end writes each byte into a two-entry queue and the token engine
// retires one queued byte per clock into the output register. A byte's token is
// registered in the output register after the byte has passed through the queue, and
// leaves from there on the result channel. in_stall rises only when the queue is full,
// which happens when out_stall holds a token in the output register.

module protobuf_wire_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pwt_pkg::pwt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pwt_pkg::pwt_out_t out_data
);
  import pwt_pkg::*;

  logic       q_valid;
  logic       q_pop;
  pwt_class_t q_head;

  // Accept and classify bytes; queue them.
  pwt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // Advance the field state machine and hold each token until transferred.
  pwt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the protobuf wire tokenizer.
`timescale 1ns / 1ps

module tb_top;
  import pwt_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 8;
  localparam int ITEM_TARGET      = 1475;  // directed rows plus about 1450 random bytes
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_LIMIT      = 4000;
  localparam int SETTLE_CYCLES    = 8;

  // Wire types that the package leaves unnamed; both are rejected.
  localparam logic [2:0] WT_START_GROUP = 3'd3;
  localparam logic [2:0] WT_SPARE7      = 3'd7;

  // Where the scanner stands inside the current field.
  typedef enum logic [2:0] {
    SCAN_TAG, SCAN_VARINT, SCAN_FIXED, SCAN_LENGTH, SCAN_PAYLOAD, SCAN_DRAIN
  } scan_phase_e;

  // One row of the directed script: the byte, and optionally a token written out by hand.
  typedef struct packed {
    pwt_in_t  item;
    logic     typed;
    logic     has_token;
    pwt_out_t token;
  } script_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pwt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pwt_out_t out_data;

  protobuf_wire_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Scanner state of the predictor, mirroring one nesting level of the wire format.
  scan_phase_e scan_phase;
  logic [63:0] scan_acc;
  logic [6:0]  scan_shift;
  logic [28:0] scan_field;
  logic [2:0]  scan_wire;
  logic [3:0]  scan_fixed_left;
  logic [63:0] scan_payload_left;

  pwt_out_t    pending_tokens[$];   // tokens owed by the block, oldest first
  script_row_t script[$];
  logic [7:0]  msg_bytes[$];        // message under construction

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  blocked_cycles = 0;
  int  kind_seen[8];
  bit  sender_calm = 1'b0;
  bit  receiver_calm = 1'b0;
  bit  long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_scanner();
    scan_phase        = SCAN_TAG;
    scan_acc          = '0;
    scan_shift        = '0;
    scan_field        = '0;
    scan_wire         = '0;
    scan_fixed_left   = '0;
    scan_payload_left = '0;
  endfunction

  // Fold one varint group into the accumulator; groups past bit 63 are dropped.
  // Returns 1 when the byte closes the varint.
  function automatic bit take_group(logic [7:0] b);
    if (scan_shift < 7'd64) begin
      scan_acc   = scan_acc | (64'(b[6:0]) << scan_shift);
      scan_shift = scan_shift + 7'd7;
    end
    return !b[7];
  endfunction

  // Build a token stamped with the field currently held by the scanner.
  function automatic pwt_out_t held_token(logic [2:0] kind, logic [63:0] value,
                                          logic [7:0] pay, logic [1:0] err, logic last);
    pwt_out_t t;
    t.token_kind   = kind;
    t.field_number = scan_field;
    t.wire_code    = scan_wire;
    t.field_value  = value;
    t.payload_byte = pay;
    t.error_code   = err;
    t.message_end  = last;
    return t;
  endfunction

  // Token spelled out in full, for the hand-written rows of the script.
  function automatic pwt_out_t spell_token(logic [2:0] kind, logic [28:0] field,
                                           logic [2:0] wt, logic [63:0] value,
                                           logic [7:0] pay, logic [1:0] err, logic last);
    pwt_out_t t;
    t.token_kind   = kind;
    t.field_number = field;
    t.wire_code    = wt;
    t.field_value  = value;
    t.payload_byte = pay;
    t.error_code   = err;
    t.message_end  = last;
    return t;
  endfunction

  // Advance the scanner by one byte; returns 1 when the byte yields a token.
  function automatic bit tokenize_byte(input pwt_in_t item, output pwt_out_t tok);
    logic [7:0]  b;
    logic        last;
    bit          made;
    logic [63:0] len;
    b    = item.data_byte;
    last = item.end_of_buffer;
    made = 1'b0;
    tok  = '0;
    case (scan_phase)
      SCAN_TAG: begin
        if (!take_group(b)) begin
          // tag cut off: field and wire type are still zero here
          if (last) begin
            tok  = held_token(KIND_ERROR, '0, '0, ERR_TRUNCATED, last);
            made = 1'b1;
          end
        end else begin
          scan_field = scan_acc[31:3];
          scan_wire  = scan_acc[2:0];
          scan_acc   = '0;
          scan_shift = '0;
          case (scan_wire)
            WT_VARINT:  scan_phase = SCAN_VARINT;
            WT_LEN:     scan_phase = SCAN_LENGTH;
            WT_FIXED64: begin
              scan_phase      = SCAN_FIXED;
              scan_fixed_left = FIXED64_BYTES;
            end
            WT_FIXED32: begin
              scan_phase      = SCAN_FIXED;
              scan_fixed_left = FIXED32_BYTES;
            end
            default: begin
              // unknown wire type wins over truncation
              tok        = held_token(KIND_ERROR, '0, '0, ERR_WIRE_TYPE, last);
              made       = 1'b1;
              scan_phase = SCAN_DRAIN;
            end
          endcase
          if (!made && last) begin
            tok  = held_token(KIND_ERROR, '0, '0, ERR_TRUNCATED, last);
            made = 1'b1;
          end
        end
      end
      SCAN_VARINT: begin
        if (take_group(b)) begin
          tok  = held_token(KIND_VARINT, scan_acc, '0, ERR_NONE, last);
          made = 1'b1;
          clear_scanner();
        end else if (last) begin
          tok  = held_token(KIND_ERROR, '0, '0, ERR_TRUNCATED, last);
          made = 1'b1;
        end
      end
      SCAN_FIXED: begin
        if (scan_shift < 7'd64) begin
          scan_acc   = scan_acc | (64'(b) << scan_shift);
          scan_shift = scan_shift + 7'd8;
        end
        if (scan_fixed_left != 0) scan_fixed_left = scan_fixed_left - 4'd1;
        if (scan_fixed_left == 0) begin
          tok  = held_token((scan_wire == WT_FIXED64) ? KIND_FIXED64 : KIND_FIXED32,
                            scan_acc, '0, ERR_NONE, last);
          made = 1'b1;
          clear_scanner();
        end else if (last) begin
          tok  = held_token(KIND_ERROR, '0, '0, ERR_TRUNCATED, last);
          made = 1'b1;
        end
      end
      SCAN_LENGTH: begin
        if (take_group(b)) begin
          len  = scan_acc;
          made = 1'b1;
          if (last && len != 0) begin
            tok = held_token(KIND_ERROR, '0, '0, ERR_TRUNCATED, last);
          end else begin
            tok = held_token(KIND_HEADER, len, '0, ERR_NONE, last);
            if (len == 0) begin
              clear_scanner();
            end else begin
              scan_phase        = SCAN_PAYLOAD;
              scan_payload_left = len;
              scan_acc          = '0;
              scan_shift        = '0;
            end
          end
        end else if (last) begin
          tok  = held_token(KIND_ERROR, '0, '0, ERR_TRUNCATED, last);
          made = 1'b1;
        end
      end
      SCAN_PAYLOAD: begin
        if (scan_payload_left != 0) scan_payload_left = scan_payload_left - 64'd1;
        made = 1'b1;
        if (last && scan_payload_left != 0) begin
          tok = held_token(KIND_ERROR, '0, '0, ERR_TRUNCATED, last);
        end else begin
          // value counts the payload bytes still to come
          tok = held_token(KIND_PAYLOAD, scan_payload_left, b, ERR_NONE, last);
          if (scan_payload_left == 0) clear_scanner();
        end
      end
      default: ;  // drain: swallow silently
    endcase
    if (last) clear_scanner();
    return made;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(logic [7:0] b, logic last);
    script_row_t r;
    r = '0;
    r.item.data_byte     = b;
    r.item.end_of_buffer = last;
    script.insert(script.size(), r);
  endtask

  task automatic add_typed(logic [7:0] b, logic last, logic has, pwt_out_t tok);
    script_row_t r;
    r.item.data_byte     = b;
    r.item.end_of_buffer = last;
    r.typed              = 1'b1;
    r.has_token          = has;
    r.token              = tok;
    script.insert(script.size(), r);
  endtask

  // Offer one byte after a random gap and hold it until the transfer; report the
  // token the predictor owes for it.
  task automatic send_byte(input pwt_in_t item, output bit made, output pwt_out_t tok);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    made = tokenize_byte(item, tok);
    bytes_sent++;
  endtask

  task automatic put_varint(logic [63:0] v);
    do begin
      msg_bytes.insert(msg_bytes.size(), {|v[63:7], v[6:0]});
      v = v >> 7;
    end while (v != 0);
  endtask

  // Field numbers: mostly small, with zero, the 29-bit ceiling and oversized ones
  // whose upper bits the tokenizer must drop.
  task automatic put_tag(logic [2:0] wt);
    logic [60:0] field;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: field = 61'($urandom_range(1, 15));
      5:             field = '0;
      6:             field = 61'h1FFF_FFFF;
      7:             field = 61'($urandom) & 61'h1FFF_FFFF;
      8:             field = 61'({$urandom, $urandom});
      default:       field = 61'($urandom_range(16, 2047));
    endcase
    put_varint({field, wt});
  endtask

  function automatic logic [63:0] draw_value();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  // Assemble one message of one to five fields into msg_bytes, not always well formed.
  task automatic build_message();
    int          fields;
    int          f;
    int          pick;
    int          len;
    int          k;
    logic [63:0] v;
    logic [2:0]  wt;
    msg_bytes.delete();
    fields = $urandom_range(1, 5);
    for (f = 0; f < fields; f++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        put_tag(WT_VARINT);
        put_varint(draw_value());
      end else if (pick < 30) begin
        // overlong varint: groups beyond bit 63 get dropped
        put_tag(WT_VARINT);
        len = $urandom_range(9, 13);
        for (k = 0; k < len; k++) begin
          msg_bytes.insert(msg_bytes.size(), {k != len - 1, 7'($urandom)});
        end
      end else if (pick < 42) begin
        put_tag(WT_FIXED32);
        v = draw_value();
        for (k = 0; k < 4; k++) msg_bytes.insert(msg_bytes.size(), v[8 * k +: 8]);
      end else if (pick < 54) begin
        put_tag(WT_FIXED64);
        v = draw_value();
        for (k = 0; k < 8; k++) msg_bytes.insert(msg_bytes.size(), v[8 * k +: 8]);
      end else if (pick < 88) begin
        put_tag(WT_LEN);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
        put_varint(64'(len));
        repeat (len) msg_bytes.insert(msg_bytes.size(), 8'($urandom));
      end else if (pick < 93) begin
        // huge length that the message never delivers: end it here
        put_tag(WT_LEN);
        put_varint(draw_value() | 64'h100);
        repeat ($urandom_range(0, 3)) msg_bytes.insert(msg_bytes.size(), 8'($urandom));
        return;
      end else begin
        // uniform over 3, 4, 6, 7; the rest of the message is drained
        wt = 3'($urandom_range(3, 6));
        if (wt == WT_FIXED32) wt = WT_SPARE7;
        put_tag(wt);
        repeat ($urandom_range(0, 4)) msg_bytes.insert(msg_bytes.size(), 8'($urandom));
      end
    end
  endtask

  // Send one message: mostly well formed, some cut short, a few pure noise.
  task automatic send_message();
    int       mode;
    int       stop_at;
    int       k;
    bit       made;
    pwt_in_t  item;
    pwt_out_t tok;
    mode = $urandom_range(0, 99);
    if (mode < 8) begin
      msg_bytes.delete();
      repeat ($urandom_range(1, 12)) msg_bytes.insert(msg_bytes.size(), 8'($urandom));
      stop_at = msg_bytes.size() - 1;
    end else begin
      build_message();
      stop_at = (mode < 22) ? $urandom_range(0, msg_bytes.size() - 1)
                            : msg_bytes.size() - 1;
    end
    for (k = 0; k <= stop_at; k++) begin
      item.data_byte     = msg_bytes[k];
      item.end_of_buffer = (k == stop_at) || (mode < 8 && $urandom_range(0, 7) == 0);
      send_byte(item, made, tok);
      if (made) pending_tokens.insert(pending_tokens.size(), tok);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Compare each transfer on the result channel with the oldest owed token.
  always @(posedge clk) begin : watch_tokens
    pwt_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, got %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 64'(want.token_kind), 64'(out_data.token_kind));
        check_field("field_number", 64'(want.field_number), 64'(out_data.field_number));
        check_field("wire_code", 64'(want.wire_code), 64'(out_data.wire_code));
        check_field("field_value", want.field_value, out_data.field_value);
        check_field("payload_byte", 64'(want.payload_byte), 64'(out_data.payload_byte));
        check_field("error_code", 64'(want.error_code), 64'(out_data.error_code));
        check_field("message_end", 64'(want.message_end), 64'(out_data.message_end));
        kind_seen[out_data.token_kind]++;
      end
    end
  end

  // Count cycles where the block pushes back on an offered byte.
  always @(posedge clk) begin
    if (in_valid && in_stall) blocked_cycles++;
  end

  // Receiver: stall a random number of cycles before each transfer; on request,
  // hold off for a long stretch so the block fills and stalls its input.
  initial begin : result_sink
    int hold;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req && !hold_done) begin
        hold      = LONG_HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        hold = receiver_calm ? 0 : $urandom_range(0, 13);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    script_row_t row;
    bit          made;
    pwt_out_t    tok;
    bit          hold_asked;
    bit          drained_once;
    int          guard;
    int          i;
    hold_asked   = 1'b0;
    drained_once = 1'b0;
    clear_scanner();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script. Hand-written tokens where they are obvious; the predictor
    // covers the rest.
    add_row(8'h08, 1'b0);                          // tag: field 1, varint
    add_typed(8'h00, 1'b0, 1'b1,
              spell_token(KIND_VARINT, 29'd1, WT_VARINT, '0, '0, ERR_NONE, 1'b0));
    add_row(8'h0D, 1'b0);                          // tag: field 1, fixed32
    add_row(8'h78, 1'b0);
    add_row(8'h56, 1'b0);
    add_row(8'h34, 1'b0);
    add_row(8'h12, 1'b0);
    add_row(8'h11, 1'b0);                          // tag: field 2, fixed64, all ones
    for (i = 0; i < 7; i++) add_row(8'hFF, 1'b0);
    add_typed(8'hFF, 1'b0, 1'b1,
              spell_token(KIND_FIXED64, 29'd2, WT_FIXED64, '1, '0, ERR_NONE, 1'b0));
    add_row(8'h1A, 1'b0);                          // field 3, two payload bytes
    add_row(8'h02, 1'b0);
    add_row(8'hAB, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h22, 1'b0);                          // field 4, empty payload
    add_row(8'h00, 1'b0);
    add_typed(8'h1B, 1'b0, 1'b1,                   // unknown wire type, then drain
              spell_token(KIND_ERROR, 29'd3, WT_START_GROUP, '0, '0, ERR_WIRE_TYPE, 1'b0));
    add_typed(8'hFF, 1'b1, 1'b0, '0);              // drained last byte: silent
    add_typed(8'h80, 1'b1, 1'b1,                   // tag cut off by end of buffer
              spell_token(KIND_ERROR, '0, WT_VARINT, '0, '0, ERR_TRUNCATED, 1'b1));
    add_typed(8'h0F, 1'b1, 1'b1,                   // unknown type beats truncation
              spell_token(KIND_ERROR, 29'd1, WT_SPARE7, '0, '0, ERR_WIRE_TYPE, 1'b1));

    for (i = 0; i < script.size(); i++) begin
      row = script[i];
      send_byte(row.item, made, tok);
      if (row.typed) begin
        if (row.has_token) pending_tokens.insert(pending_tokens.size(), row.token);
      end else if (made) begin
        pending_tokens.insert(pending_tokens.size(), tok);
      end
    end

    // Random messages; flip each side between idling and streaming now and then.
    while (bytes_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) sender_calm = !sender_calm;
      if ($urandom_range(0, 5) == 0) receiver_calm = !receiver_calm;
      if (!hold_asked && bytes_sent >= 500) begin
        // long receiver hold-off while the sender streams
        hold_asked    = 1'b1;
        long_hold_req = 1'b1;
        sender_calm   = 1'b1;
      end
      if (!drained_once && bytes_sent >= 900) begin
        // drop valid and wait until the block has delivered everything owed
        drained_once = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0) @(posedge clk);
      end
      send_message();
    end
    in_valid <= 1'b0;

    // Let the last tokens drain, then allow a few more cycles for strays.
    guard = 0;
    while (pending_tokens.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_tokens.size() != 0) begin
      $display("%0t: %0d tokens never arrived, expected next %h, got nothing",
               $time, pending_tokens.size(), pending_tokens[0]);
      mismatches++;
    end

    $write("Fed %0d bytes (%0d scripted); checked tokens: ", bytes_sent, script.size());
    $display("%0d varint, %0d fixed32, %0d fixed64, %0d header, %0d payload, %0d error.",
             kind_seen[KIND_VARINT], kind_seen[KIND_FIXED32], kind_seen[KIND_FIXED64],
             kind_seen[KIND_HEADER], kind_seen[KIND_PAYLOAD], kind_seen[KIND_ERROR]);
    $display("Input stalled on %0d cycles; ran one long output hold-off and one full drain.",
             blocked_cycles);
    if (mismatches == 0) begin
      $display("protobuf_wire_tokenizer test passed");
    end else begin
      $display("protobuf_wire_tokenizer test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("%0t: timeout with %0d tokens still owed", $time, pending_tokens.size());
    $display("protobuf_wire_tokenizer test failed");
    $finish;
  end

endmodule

/* filelist.f */
hdl/pwt_pkg.sv
hdl/pwt_front.sv
hdl/pwt_back.sv
hdl/protobuf_wire_tokenizer.sv
dv/tb_top.sv
